### sv/adtsd_pkg.sv
`timescale 1ns / 1ps

package adtsd_pkg;

    localparam int unsigned WIN_LEN    = 6;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PADDR_W    = 3;

    // Register index, taken from the word address paddr[2].
    localparam logic REG_BUFFER_LENGTH = 1'b0;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_LAST    = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  profile;
        logic [3:0]  freq_idx;
        logic [16:0] sampling_hz;
        logic [2:0]  chan_cfg;
        logic [12:0] frame_len;
        logic [10:0] fullness;
        logic [2:0]  raw_blocks;
        logic        crc_flag;
        logic [29:0] frame_count;
        logic        last_of_run;
    } result_t;

    // Up to two results pushed into the output queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [16:0] sampling_hz_of(input logic [3:0] idx);
        logic [16:0] rate;
        case (idx)
            4'd0:    rate = 17'd96000;
            4'd1:    rate = 17'd88200;
            4'd2:    rate = 17'd64000;
            4'd3:    rate = 17'd48000;
            4'd4:    rate = 17'd44100;
            4'd5:    rate = 17'd32000;
            4'd6:    rate = 17'd24000;
            4'd7:    rate = 17'd22050;
            4'd8:    rate = 17'd16000;
            4'd9:    rate = 17'd12000;
            4'd10:   rate = 17'd11025;
            4'd11:   rate = 17'd8000;
            4'd12:   rate = 17'd7350;
            default: rate = 17'd0;
        endcase
        return rate;
    endfunction

endpackage

### sv/adtsd_in_if.sv
`timescale 1ns / 1ps

interface adtsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_buffer;

    modport source (output valid, output data_byte, output first_of_buffer, input ready);
    modport sink (input valid, input data_byte, input first_of_buffer, output ready);
endinterface

### sv/adtsd_out_if.sv
`timescale 1ns / 1ps

interface adtsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [2:0]  profile;
    logic [3:0]  freq_idx;
    logic [16:0] sampling_hz;
    logic [2:0]  chan_cfg;
    logic [12:0] frame_len;
    logic [10:0] fullness;
    logic [2:0]  raw_blocks;
    logic        crc_flag;
    logic [29:0] frame_count;
    logic        last_of_run;

    modport source (
        output valid, output kind, output payload_byte, output profile,
        output freq_idx, output sampling_hz, output chan_cfg,
        output frame_len, output fullness, output raw_blocks,
        output crc_flag, output frame_count, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input profile,
        input freq_idx, input sampling_hz, input chan_cfg,
        input frame_len, input fullness, input raw_blocks,
        input crc_flag, input frame_count, input last_of_run,
        output ready
    );
endinterface

### sv/adtsd_fifo.sv
`timescale 1ns / 1ps

module adtsd_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  adtsd_pkg::push_t        push,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_ready,
    output adtsd_pkg::result_t      out_data
);

    localparam int unsigned PTR_W = $clog2(adtsd_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    adtsd_pkg::result_t mem_reg [adtsd_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign room      = (count_reg <= CNT_W'(adtsd_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wptr_next  = wptr_reg + PTR_W'(push.count);
        rptr_next  = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wptr_reg + PTR_W'(1)] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/adtsd_core.sv
`timescale 1ns / 1ps

module adtsd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                first_of_buffer,
    input  logic [31:0]         buffer_length,
    output adtsd_pkg::push_t    push
);

    localparam int unsigned FILL_W = $clog2(adtsd_pkg::WIN_LEN + 1);

    logic [31:0]       pos_reg;
    logic [31:0]       pos_next;
    logic [7:0]        win_reg [adtsd_pkg::WIN_LEN];
    logic [7:0]        win_next [adtsd_pkg::WIN_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [12:0]       left_reg;
    logic [12:0]       left_next;
    logic [1:0]        crc_left_reg;
    logic [1:0]        crc_left_next;
    logic [29:0]       frames_reg;
    logic [29:0]       frames_next;

    logic [31:0]       pos;
    logic [7:0]        win [adtsd_pkg::WIN_LEN];
    logic [FILL_W-1:0] fill;
    logic              in_frame;
    logic [12:0]       left;
    logic [1:0]        crc_left;
    logic [29:0]       frames;

    logic              past_end;
    logic              at_end;
    logic [12:0]       left_dec;
    logic [12:0]       fl;
    logic [12:0]       body_len;
    logic [32:0]       remain;
    logic              hdr_ok;
    logic              has_crc;
    logic [12:0]       hdr_len;
    adtsd_pkg::result_t r0;
    adtsd_pkg::result_t r1;
    logic [1:0]        n;

    always_comb
    begin
        // A first byte restarts the walk before it is taken as position 0.
        pos      = first_of_buffer ? '0 : pos_reg;
        fill     = first_of_buffer ? '0 : fill_reg;
        in_frame = first_of_buffer ? 1'b0 : in_frame_reg;
        left     = first_of_buffer ? '0 : left_reg;
        crc_left = first_of_buffer ? '0 : crc_left_reg;
        frames   = first_of_buffer ? '0 : frames_reg;
        for (int i = 0; i < adtsd_pkg::WIN_LEN; i++)
        begin
            win[i] = first_of_buffer ? 8'd0 : win_reg[i];
        end

        past_end = (pos >= buffer_length);
        at_end   = (({1'b0, pos} + 33'd1) == {1'b0, buffer_length});
        left_dec = left - 13'd1;
        fl       = {win[3][1:0], win[4], win[5][7:5]};
        body_len = fl - 13'd7;
        remain   = {1'b0, buffer_length} - {1'b0, pos} + 33'd6;
        has_crc  = ~win[1][0];
        hdr_len  = has_crc ? 13'd9 : 13'd7;
        hdr_ok   = (win[0] == 8'hFF) && (win[1][7:4] == 4'hF) && (fl >= 13'd7)
                   && ({20'd0, fl} <= remain);

        pos_next      = pos;
        fill_next     = fill;
        in_frame_next = in_frame;
        left_next     = left;
        crc_left_next = crc_left;
        frames_next   = frames;
        win_next      = win;
        r0            = '0;
        r1            = '0;
        n             = 2'd0;

        if (!past_end)
        begin
            if (in_frame)
            begin
                left_next = left_dec;
                if (crc_left != 2'd0)
                begin
                    crc_left_next = crc_left - 2'd1;
                end
                else
                begin
                    r0.kind = (left_dec == 13'd0) ? adtsd_pkg::KIND_LAST
                                                  : adtsd_pkg::KIND_PAYLOAD;
                    r0.payload_byte = data_byte;
                    n = 2'd1;
                end
                if (left_dec == 13'd0)
                begin
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                end
            end
            else if (fill < FILL_W'(adtsd_pkg::WIN_LEN))
            begin
                for (int i = 0; i < adtsd_pkg::WIN_LEN; i++)
                begin
                    if (fill == FILL_W'(i))
                    begin
                        win_next[i] = data_byte;
                    end
                end
                fill_next = fill + FILL_W'(1);
            end
            else if (hdr_ok)
            begin
                frames_next = frames + 30'd1;
                if (fl > hdr_len)
                begin
                    r0.kind        = adtsd_pkg::KIND_HEADER;
                    r0.profile     = {1'b0, win[2][7:6]} + 3'd1;
                    r0.freq_idx    = win[2][5:2];
                    r0.sampling_hz = adtsd_pkg::sampling_hz_of(win[2][5:2]);
                    r0.chan_cfg    = {win[2][0], win[3][7:6]};
                    r0.frame_len   = fl;
                    r0.fullness    = {win[5][4:0], data_byte[7:2]};
                    r0.raw_blocks  = {1'b0, data_byte[1:0]} + 3'd1;
                    r0.crc_flag    = has_crc;
                    r0.frame_count = frames + 30'd1;
                    n = 2'd1;
                end
                left_next = body_len;
                fill_next = '0;
                if (body_len != 13'd0)
                begin
                    in_frame_next = 1'b1;
                    if (!has_crc)
                    begin
                        crc_left_next = 2'd0;
                    end
                    else if (body_len < 13'd2)
                    begin
                        crc_left_next = body_len[1:0];
                    end
                    else
                    begin
                        crc_left_next = 2'd2;
                    end
                end
                else
                begin
                    in_frame_next = 1'b0;
                    crc_left_next = 2'd0;
                end
            end
            else
            begin
                for (int i = 0; i < adtsd_pkg::WIN_LEN - 1; i++)
                begin
                    win_next[i] = win[i + 1];
                end
                win_next[adtsd_pkg::WIN_LEN - 1] = data_byte;
            end

            if (at_end)
            begin
                if (n == 2'd0)
                begin
                    r0.kind        = adtsd_pkg::KIND_DONE;
                    r0.frame_count = frames_next;
                end
                else
                begin
                    r1.kind        = adtsd_pkg::KIND_DONE;
                    r1.frame_count = frames_next;
                end
                n = n + 2'd1;
            end
            pos_next = pos + 32'd1;
        end

        if (n == 2'd1)
        begin
            r0.last_of_run = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last_of_run = 1'b1;
        end

        push.count = step ? n : 2'd0;
        push.res0  = r0;
        push.res1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            left_reg     <= '0;
            crc_left_reg <= '0;
            frames_reg   <= '0;
            for (int i = 0; i < adtsd_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            left_reg     <= left_next;
            crc_left_reg <= crc_left_next;
            frames_reg   <= frames_next;
            for (int i = 0; i < adtsd_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

### sv/adts_frame_deframer.sv
`timescale 1ns / 1ps

// ADTS frame sync over a buffer of known length.
// Load buffer_length through the APB port (byte address 0) while the block is
// idle, then send the buffer one byte per beat on in_ch, with first_of_buffer
// set on the opening byte. Each byte gives zero, one or two beats on out_ch:
// a decoded header when a valid frame is found, the frame's payload bytes
// (CRC bytes dropped, the final one marked), and a walk-finished beat with
// the frame total when the last byte of the buffer arrives.
// A byte is registered on acceptance and decoded from that register into a
// four-entry result queue, whose head is offered on out_ch; decoding waits
// while the queue lacks room for two more results.
// One byte is accepted every cycle while the queue holds at most two results;
// a byte that yields two results holds up later bytes only if the receiver
// cannot drain the queue faster than the bytes arrive.
// When out_ch stalls the queue fills and in_ch.ready falls; nothing is lost.
// Reset clears the walk state, the queue and buffer_length (to zero, so no
// byte produces results until the length is written).

module adts_frame_deframer
(
    input  logic                              clk,
    input  logic                              rst_n,
    adtsd_in_if.sink                          in_ch,
    adtsd_out_if.source                       out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [adtsd_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic               len_wr;
    logic [31:0]        length_reg;
    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic [7:0]         stage_byte_reg;
    logic               stage_first_reg;
    logic               room;
    logic               step;
    logic               in_fire;
    adtsd_pkg::push_t   push;
    adtsd_pkg::result_t head;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == adtsd_pkg::REG_BUFFER_LENGTH) ? length_reg : 32'd0;
    assign len_wr  = psel && penable && pwrite
                     && (paddr[2] == adtsd_pkg::REG_BUFFER_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= 32'd0;
        end
        else if (len_wr)
        begin
            length_reg <= pwdata;
        end
    end

    assign step         = stage_valid_reg && room;
    assign in_ch.ready  = !stage_valid_reg || room;
    assign in_fire      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (step)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_byte_reg  <= in_ch.data_byte;
            stage_first_reg <= in_ch.first_of_buffer;
        end
    end

    adtsd_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (stage_byte_reg),
        .first_of_buffer (stage_first_reg),
        .buffer_length   (length_reg),
        .push            (push)
    );

    adtsd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (head)
    );

    assign out_ch.kind         = head.kind;
    assign out_ch.payload_byte = head.payload_byte;
    assign out_ch.profile      = head.profile;
    assign out_ch.freq_idx     = head.freq_idx;
    assign out_ch.sampling_hz  = head.sampling_hz;
    assign out_ch.chan_cfg     = head.chan_cfg;
    assign out_ch.frame_len    = head.frame_len;
    assign out_ch.fullness     = head.fullness;
    assign out_ch.raw_blocks   = head.raw_blocks;
    assign out_ch.crc_flag     = head.crc_flag;
    assign out_ch.frame_count  = head.frame_count;
    assign out_ch.last_of_run  = head.last_of_run;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_ITEMS  = 1450;
    localparam logic [adtsd_pkg::PADDR_W-1:0] LEN_ADDR =
        {adtsd_pkg::REG_BUFFER_LENGTH, 2'b00};

    localparam logic [16:0] RATE_HZ [16] = '{
        17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
        17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
        17'd7350, 17'd0, 17'd0, 17'd0
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [adtsd_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    adtsd_in_if  in_ch ();
    adtsd_out_if out_ch ();

    adts_frame_deframer dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted walk state of the deframer.
    logic [31:0] cfg_length;
    logic [31:0] walk_pos;
    logic [7:0]  win [adtsd_pkg::WIN_LEN];
    int unsigned win_fill;
    bit          in_frame;
    logic [12:0] frame_left;
    logic [1:0]  crc_left;
    logic [29:0] frames_seen;

    adtsd_pkg::result_t pending_results [$];
    logic [7:0]  stream_q [$];
    bit          first_q [$];
    int unsigned mismatches = 0;
    int unsigned random_items;
    bit          sender_idle;
    bit          receiver_idle;
    bit          hold_off_req;

    function automatic void restart_walk();
        int unsigned i;
        walk_pos = '0;
        for (i = 0; i < adtsd_pkg::WIN_LEN; i++)
        begin
            win[i] = '0;
        end
        win_fill    = 0;
        in_frame    = 1'b0;
        frame_left  = '0;
        crc_left    = '0;
        frames_seen = '0;
    endfunction

    function automatic void predict_deframe(input logic [7:0] b, input bit first);
        adtsd_pkg::result_t res [2];
        int unsigned     n;
        int unsigned     i;
        logic [12:0]     fl;
        longint unsigned remain;
        bit              crc;
        logic [3:0]      fi;
        n = 0;
        if (first)
        begin
            restart_walk();
        end
        if (walk_pos >= cfg_length)
        begin
            return;
        end
        if (in_frame)
        begin
            frame_left = frame_left - 13'd1;
            if (crc_left != 2'd0)
            begin
                crc_left = crc_left - 2'd1;
            end
            else
            begin
                res[n] = '0;
                res[n].kind = (frame_left == 13'd0) ? adtsd_pkg::KIND_LAST
                                                    : adtsd_pkg::KIND_PAYLOAD;
                res[n].payload_byte = b;
                n++;
            end
            if (frame_left == 13'd0)
            begin
                in_frame = 1'b0;
                win_fill = 0;
            end
        end
        else if (win_fill < adtsd_pkg::WIN_LEN)
        begin
            win[win_fill] = b;
            win_fill++;
        end
        else
        begin
            fl = {win[3][1:0], win[4], win[5][7:5]};
            // Bytes left counted from the first byte of the window.
            remain = 64'(cfg_length) - 64'(walk_pos) + 64'd6;
            if (win[0] == 8'hFF && win[1][7:4] == 4'hF && fl >= 13'd7 && 64'(fl) <= remain)
            begin
                crc = ~win[1][0];
                fi = win[2][5:2];
                frames_seen = frames_seen + 30'd1;
                if (fl > (crc ? 13'd9 : 13'd7))
                begin
                    res[n] = '0;
                    res[n].kind        = adtsd_pkg::KIND_HEADER;
                    res[n].profile     = 3'(win[2][7:6]) + 3'd1;
                    res[n].freq_idx    = fi;
                    res[n].sampling_hz = RATE_HZ[fi];
                    res[n].chan_cfg    = {win[2][0], win[3][7:6]};
                    res[n].frame_len   = fl;
                    res[n].fullness    = {win[5][4:0], b[7:2]};
                    res[n].raw_blocks  = 3'(b[1:0]) + 3'd1;
                    res[n].crc_flag    = crc;
                    res[n].frame_count = frames_seen;
                    n++;
                end
                frame_left = fl - 13'd7;
                win_fill = 0;
                in_frame = (frame_left != 13'd0);
                if (crc && in_frame)
                begin
                    crc_left = (frame_left < 13'd2) ? 2'(frame_left) : 2'd2;
                end
                else
                begin
                    crc_left = 2'd0;
                end
            end
            else
            begin
                for (i = 0; i < adtsd_pkg::WIN_LEN - 1; i++)
                begin
                    win[i] = win[i + 1];
                end
                win[adtsd_pkg::WIN_LEN - 1] = b;
            end
        end
        if (64'(walk_pos) + 64'd1 == 64'(cfg_length))
        begin
            res[n] = '0;
            res[n].kind = adtsd_pkg::KIND_DONE;
            res[n].frame_count = frames_seen;
            n++;
        end
        walk_pos = walk_pos + 32'd1;
        if (n > 0)
        begin
            res[n - 1].last_of_run = 1'b1;
        end
        for (i = 0; i < n; i++)
        begin
            pending_results.push_back(res[i]);
        end
    endfunction

    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        if (!enabled)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic void set_idle_mode();
        int unsigned m;
        m = $urandom_range(0, 3);
        sender_idle   = (m == 0) || (m == 2);
        receiver_idle = (m == 0) || (m == 3);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        adtsd_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat of kind %0d", out_ch.kind);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_ch.kind));
                check_field("payload_byte", 32'(want.payload_byte),
                            32'(out_ch.payload_byte));
                check_field("profile", 32'(want.profile), 32'(out_ch.profile));
                check_field("freq_idx", 32'(want.freq_idx), 32'(out_ch.freq_idx));
                check_field("sampling_hz", 32'(want.sampling_hz),
                            32'(out_ch.sampling_hz));
                check_field("chan_cfg", 32'(want.chan_cfg), 32'(out_ch.chan_cfg));
                check_field("frame_len", 32'(want.frame_len), 32'(out_ch.frame_len));
                check_field("fullness", 32'(want.fullness), 32'(out_ch.fullness));
                check_field("raw_blocks", 32'(want.raw_blocks), 32'(out_ch.raw_blocks));
                check_field("crc_flag", 32'(want.crc_flag), 32'(out_ch.crc_flag));
                check_field("frame_count", 32'(want.frame_count),
                            32'(out_ch.frame_count));
                check_field("last_of_run", 32'(want.last_of_run),
                            32'(out_ch.last_of_run));
            end
        end
    end

    // The receiver stalls at random and, when asked, holds off for a long stretch.
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap(receiver_idle);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit first);
        int unsigned gap;
        @(negedge clk);
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= b;
        in_ch.first_of_buffer <= first;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predict_deframe(b, first);
        gap = pick_gap(sender_idle);
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_span(input int unsigned lo, input int unsigned hi);
        int unsigned i;
        for (i = lo; i < hi; i++)
        begin
            send_byte(stream_q[i], first_q[i]);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= LEN_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_length(input logic [31:0] len);
        logic [31:0] readback;
        drain();
        apb_access(1'b1, len, readback);
        cfg_length = len;
        apb_access(1'b0, 32'd0, readback);
        if (readback !== len)
        begin
            $error("buffer_length: expected %0d, got %0d", len, readback);
            mismatches++;
        end
    endtask

    function automatic void add_byte(input logic [7:0] b);
        stream_q.push_back(b);
        first_q.push_back(1'b0);
    endfunction

    function automatic void add_frame(input int unsigned fl, input bit crc,
                                      input bit good_sync, input int unsigned body);
        logic [12:0] len13;
        logic [10:0] fullness;
        logic [7:0]  h0;
        logic [7:0]  h1;
        int unsigned i;
        len13 = 13'(fl);
        fullness = 11'($urandom);
        h0 = 8'hFF;
        h1 = {4'hF, 3'($urandom), ~crc};
        if (!good_sync)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                h0 = 8'($urandom_range(0, 254));
            end
            else
            begin
                h1[7:4] = 4'($urandom_range(0, 14));
            end
        end
        add_byte(h0);
        add_byte(h1);
        add_byte(8'($urandom));
        add_byte({6'($urandom), len13[12:11]});
        add_byte(len13[10:3]);
        add_byte({len13[2:0], fullness[10:6]});
        add_byte({fullness[5:0], 2'($urandom)});
        for (i = 0; i < body; i++)
        begin
            add_byte(8'($urandom));
        end
    endfunction

    function automatic int unsigned pick_frame_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            return $urandom_range(7, 9);
        end
        if (r < 80)
        begin
            return $urandom_range(10, 24);
        end
        return $urandom_range(25, 80);
    endfunction

    // Mostly well-formed frames, with noise, broken sync and bad lengths between them.
    function automatic void build_stream(input int unsigned parts, input bit clean);
        int unsigned i;
        int unsigned j;
        int unsigned sel;
        int unsigned fl;
        stream_q.delete();
        first_q.delete();
        for (i = 0; i < parts; i++)
        begin
            sel = clean ? 0 : $urandom_range(0, 99);
            if (sel < 65)
            begin
                fl = pick_frame_len();
                add_frame(fl, 1'($urandom_range(0, 1)), 1'b1, fl - 7);
            end
            else if (sel < 74)
            begin
                add_frame($urandom_range(0, 6), 1'($urandom_range(0, 1)), 1'b1, 0);
            end
            else if (sel < 82)
            begin
                add_frame($urandom_range(200, 8191), 1'($urandom_range(0, 1)), 1'b1, 0);
            end
            else if (sel < 88)
            begin
                fl = pick_frame_len();
                add_frame(fl, 1'($urandom_range(0, 1)), 1'b0, fl - 7);
            end
            else
            begin
                for (j = $urandom_range(1, 6); j > 0; j--)
                begin
                    add_byte(($urandom_range(0, 9) < 3) ? 8'hFF : 8'($urandom));
                end
            end
        end
        first_q[0] = 1'b1;
        if (!clean && stream_q.size() > 1 && $urandom_range(0, 99) < 6)
        begin
            first_q[$urandom_range(1, stream_q.size() - 1)] = 1'b1;
        end
    endfunction

    task automatic test_zero_length();
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF1, 1'b0);
        send_byte(8'h00, 1'b0);
        set_length(32'd0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7E, 1'b0);
    endtask

    task automatic test_header_extremes();
        set_length(32'd9);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF1, 1'b0);
        send_byte(8'hFD, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Past the end of the buffer.
        send_byte(8'h55, 1'b0);
    endtask

    task automatic test_crc_and_short_frames();
        set_length(32'd16);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h50, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF9, 1'b0);
        send_byte(8'h4C, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_length_extremes();
        set_idle_mode();
        build_stream(6, 1'b0);
        set_length(32'hFFFF_FFFF);
        send_span(0, stream_q.size());
    endtask

    task automatic test_backpressure();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        build_stream(4, 1'b1);
        set_length(32'(stream_q.size()));
        hold_off_req = 1'b1;
        send_span(0, stream_q.size());
        drain();
    endtask

    task automatic test_random_buffers();
        int unsigned sel;
        int unsigned size;
        int unsigned split;
        logic [31:0] len;
        while (random_items < RANDOM_ITEMS)
        begin
            set_idle_mode();
            build_stream($urandom_range(2, 8), 1'b0);
            size = stream_q.size();
            sel = $urandom_range(0, 99);
            if (sel < 60 || size <= 10)
            begin
                len = 32'(size);
            end
            else if (sel < 75)
            begin
                len = 32'(size - $urandom_range(1, 10));
            end
            else if (sel < 88)
            begin
                len = 32'(size + $urandom_range(1, 20));
            end
            else if (sel < 94)
            begin
                len = 32'd0;
            end
            else
            begin
                len = 32'hFFFF_FFFF;
            end
            set_length(len);
            if ($urandom_range(0, 99) < 20)
            begin
                // New length takes effect part-way through the walk.
                split = $urandom_range(1, size - 1);
                send_span(0, split);
                len = 32'($urandom_range(split / 2, size + 8));
                set_length(len);
                send_span(split, size);
            end
            else
            begin
                send_span(0, size);
            end
            random_items += size;
        end
    endtask

    initial
    begin : main
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = '0;
        in_ch.first_of_buffer = 1'b0;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        hold_off_req  = 1'b0;
        random_items  = 0;
        cfg_length    = '0;
        restart_walk();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_length();
        test_header_extremes();
        test_crc_and_short_frames();
        test_backpressure();
        test_length_extremes();
        test_random_buffers();

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(64'd50_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
